// ===== src/rkbd_pkg.sv =====
`timescale 1ns / 1ps

package rkbd_pkg;

    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;
    localparam int KEY_W  = 128;
    localparam int SN_W   = 7;
    localparam int POS_W  = 4;

    localparam logic [POS_W-1:0] POS_A_INIT = 4'd0;
    localparam logic [POS_W-1:0] POS_B_INIT = 4'd8;
    localparam logic [POS_W:0]   POS_A_LAST = 5'd15;
    localparam logic [POS_W:0]   POS_B_LAST = 5'd12;
    localparam logic [POS_W:0]   POS_B_SPAN = 5'd8;
    localparam logic [SN_W-1:0]  SN_STEP    = 7'd2;
    localparam logic [POS_W-1:0] OFS_SWAP   = 4'd2;
    localparam logic [POS_W-1:0] OFS_NOSWAP = 4'd3;

    localparam logic [14:0] RECIP7  = 15'd147;
    localparam logic [12:0] RECIP12 = 13'd43;

    typedef enum logic [2:0] {
        REG_KEY_A_LO = 3'd0,
        REG_KEY_A_HI = 3'd1,
        REG_KEY_B_LO = 3'd2,
        REG_KEY_B_HI = 3'd3,
        REG_INIT_SN  = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [KEY_W-1:0] key_a;
        logic [KEY_W-1:0] key_b;
        logic [SN_W-1:0]  init_sn;
    } cfg_t;

    typedef struct packed {
        logic [POS_W-1:0] pos_a;
        logic [POS_W-1:0] pos_b;
        logic [SN_W-1:0]  sn;
        logic             swap;
    } state_t;

    // x mod 7 via reciprocal multiply, exact for 7-bit x
    function automatic logic [2:0] mod7(input logic [SN_W-1:0] x);
        logic [14:0]     p;
        logic [4:0]      q;
        logic [SN_W-1:0] r;
        p = 15'(x) * RECIP7;
        q = p[14:10];
        r = x - SN_W'(7'(q) * 7'd7);
        return r[2:0];
    endfunction

    // x mod 12 via reciprocal multiply, exact for 7-bit x
    function automatic logic [3:0] mod12(input logic [SN_W-1:0] x);
        logic [12:0]     p;
        logic [3:0]      q;
        logic [SN_W-1:0] r;
        p = 13'(x) * RECIP12;
        q = p[12:9];
        r = x - SN_W'(7'(q) * 7'd12);
        return r[3:0];
    endfunction

endpackage

// ===== src/rkbd_cfg_regs.sv =====
`timescale 1ns / 1ps

module rkbd_cfg_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rkbd_pkg::ADDR_W-1:0]   paddr,
    input  logic [rkbd_pkg::DATA_W-1:0]   pwdata,
    output logic [rkbd_pkg::DATA_W-1:0]   prdata,
    output rkbd_pkg::cfg_t                cfg
);

    logic [rkbd_pkg::DATA_W-1:0] key_a_lo_reg;
    logic [rkbd_pkg::DATA_W-1:0] key_a_hi_reg;
    logic [rkbd_pkg::DATA_W-1:0] key_b_lo_reg;
    logic [rkbd_pkg::DATA_W-1:0] key_b_hi_reg;
    logic [rkbd_pkg::SN_W-1:0]   init_sn_reg;
    logic                        wr_en;
    rkbd_pkg::reg_idx_t          idx;

    assign wr_en = psel && penable && pwrite;
    assign idx   = rkbd_pkg::reg_idx_t'(paddr[rkbd_pkg::ADDR_W-1:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_a_lo_reg <= '0;
            key_a_hi_reg <= '0;
            key_b_lo_reg <= '0;
            key_b_hi_reg <= '0;
            init_sn_reg  <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                rkbd_pkg::REG_KEY_A_LO: key_a_lo_reg <= pwdata;
                rkbd_pkg::REG_KEY_A_HI: key_a_hi_reg <= pwdata;
                rkbd_pkg::REG_KEY_B_LO: key_b_lo_reg <= pwdata;
                rkbd_pkg::REG_KEY_B_HI: key_b_hi_reg <= pwdata;
                rkbd_pkg::REG_INIT_SN:  init_sn_reg  <= pwdata[rkbd_pkg::SN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            rkbd_pkg::REG_KEY_A_LO: prdata = key_a_lo_reg;
            rkbd_pkg::REG_KEY_A_HI: prdata = key_a_hi_reg;
            rkbd_pkg::REG_KEY_B_LO: prdata = key_b_lo_reg;
            rkbd_pkg::REG_KEY_B_HI: prdata = key_b_hi_reg;
            rkbd_pkg::REG_INIT_SN:  prdata = rkbd_pkg::DATA_W'(init_sn_reg);
            default:                prdata = '0;
        endcase
    end

    assign cfg.key_a   = {key_a_hi_reg, key_a_lo_reg};
    assign cfg.key_b   = {key_b_hi_reg, key_b_lo_reg};
    assign cfg.init_sn = init_sn_reg;

endmodule

// ===== src/rkbd_step.sv =====
`timescale 1ns / 1ps

module rkbd_step
(
    input  rkbd_pkg::cfg_t    cfg,
    input  rkbd_pkg::state_t  cur,
    input  logic [7:0]        cipher_byte,
    input  logic              restart,
    output logic [7:0]        plain_byte,
    output rkbd_pkg::state_t  nxt
);

    rkbd_pkg::state_t            st;
    logic [7:0]                  kb;
    logic [7:0]                  ka;
    logic [7:0]                  mix;
    logic [7:0]                  swp;
    logic [rkbd_pkg::POS_W:0]    na;
    logic [rkbd_pkg::POS_W:0]    nb;
    logic [rkbd_pkg::SN_W-1:0]   sn_adv;
    logic [2:0]                  m7;
    logic [3:0]                  m12;

    // restart reloads the initial state before this byte
    always_comb
    begin
        if (restart)
        begin
            st.pos_a = rkbd_pkg::POS_A_INIT;
            st.pos_b = rkbd_pkg::POS_B_INIT;
            st.sn    = cfg.init_sn;
            st.swap  = 1'b0;
        end
        else
        begin
            st = cur;
        end
    end

    assign kb  = cfg.key_b[{st.pos_b, 3'b000} +: 8];
    assign ka  = cfg.key_a[{st.pos_a, 3'b000} +: 8];
    assign mix = kb ^ {1'b0, st.sn} ^ cipher_byte;
    assign swp = st.swap ? {mix[3:0], mix[7:4]} : mix;
    assign plain_byte = swp ^ ka;

    assign na     = {1'b0, st.pos_a} + 5'd1;
    assign nb     = {1'b0, st.pos_b} + 5'd1;
    assign sn_adv = st.sn + rkbd_pkg::SN_STEP;
    assign m7     = rkbd_pkg::mod7(sn_adv);
    assign m12    = rkbd_pkg::mod12(sn_adv);

    always_comb
    begin
        nxt = st;
        priority if (na <= rkbd_pkg::POS_A_LAST)
        begin
            nxt.pos_a = na[rkbd_pkg::POS_W-1:0];
            if (nb > rkbd_pkg::POS_B_LAST)
            begin
                nxt.pos_b = '0;
                nxt.swap  = ~st.swap;
            end
            else
            begin
                nxt.pos_b = nb[rkbd_pkg::POS_W-1:0];
            end
        end
        else if (nb <= rkbd_pkg::POS_B_SPAN)
        begin
            nxt.pos_a = '0;
            nxt.pos_b = nb[rkbd_pkg::POS_W-1:0];
            nxt.swap  = ~st.swap;
        end
        else
        begin
            // both keys exhausted
            nxt.sn = sn_adv;
            if (st.swap)
            begin
                nxt.swap  = 1'b0;
                nxt.pos_a = rkbd_pkg::POS_W'(m7);
                nxt.pos_b = m12 + rkbd_pkg::OFS_SWAP;
            end
            else
            begin
                nxt.swap  = 1'b1;
                nxt.pos_b = rkbd_pkg::POS_W'(m7);
                nxt.pos_a = m12 + rkbd_pkg::OFS_NOSWAP;
            end
        end
    end

endmodule

// ===== src/rolling_key_byte_decryptor_core.sv =====
`timescale 1ns / 1ps

// channel  | direction | handshake          | payload
// input    | in        | in_valid/in_stall  | cipher_byte, restart
// output   | out       | out_valid/out_stall| plain_byte
// config   | in/out    | apb psel/penable   | paddr, pwdata, prdata
//
// one byte per cycle sustained while out_stall is low; each byte passes the input and then the output register
// input register feeds the key/state logic, which writes the output register
// key state advances when a byte moves from the input to the output register
// rst_n is asynchronous; keys clear to zero, positions to a=0 b=8
// out_stall holds the output register; in_stall rises only when both registers are full

module rolling_key_byte_decryptor_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    cipher_byte,
    input  logic                          restart,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    plain_byte,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rkbd_pkg::ADDR_W-1:0]   paddr,
    input  logic [rkbd_pkg::DATA_W-1:0]   pwdata,
    output logic [rkbd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    rkbd_pkg::cfg_t    cfg;
    rkbd_pkg::state_t  state_reg;
    rkbd_pkg::state_t  state_next;
    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_restart_reg;
    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic [7:0]        out_byte_next;
    logic              advance;
    logic              move;
    logic              take;

    assign pready = 1'b1;

    rkbd_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    rkbd_step u_step
    (
        .cfg         (cfg),
        .cur         (state_reg),
        .cipher_byte (in_byte_reg),
        .restart     (in_restart_reg),
        .plain_byte  (out_byte_next),
        .nxt         (state_next)
    );

    assign advance  = !out_valid_reg || !out_stall;
    assign move     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;
    assign take     = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            state_reg.pos_a <= rkbd_pkg::POS_A_INIT;
            state_reg.pos_b <= rkbd_pkg::POS_B_INIT;
            state_reg.sn    <= '0;
            state_reg.swap  <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (move)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_byte_reg    <= cipher_byte;
            in_restart_reg <= restart;
        end
        if (move)
        begin
            out_byte_reg <= out_byte_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign plain_byte = out_byte_reg;

endmodule

// ===== src/rkbd_checker.sv =====
`timescale 1ns / 1ps

module rkbd_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [7:0]                    cipher_byte,
    input  logic                          restart,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [7:0]                    plain_byte,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rkbd_pkg::ADDR_W-1:0]   paddr,
    input  logic [rkbd_pkg::DATA_W-1:0]   pwdata,
    input  logic [rkbd_pkg::DATA_W-1:0]   prdata,
    input  logic                          pready
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(plain_byte))
        else $error("output beat changed under stall");

    // with an empty output register the input side never stalls
    a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while output register empty");

    // an accepted byte into an idle output shows up after the input and output registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_valid |=> ##1 out_valid)
        else $error("output beat missing after input beat");

    // initial string number reads back what was written
    a_isn_rb: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready
            && paddr[rkbd_pkg::ADDR_W-1:3] == rkbd_pkg::REG_INIT_SN
        |=> (paddr != $past(paddr))
            || prdata == rkbd_pkg::DATA_W'($past(pwdata[rkbd_pkg::SN_W-1:0])))
        else $error("string number readback mismatch");

endmodule

bind rolling_key_byte_decryptor_core rkbd_checker u_rkbd_checker (.*);

// ===== tb/sv/rolling_key_byte_decryptor_core_test.sv =====
`timescale 1ns / 1ps

module rolling_key_byte_decryptor_core_test;

    import rkbd_pkg::*;

    localparam logic [ADDR_W-1:0] UNUSED_ADDR = ADDR_W'((int'(REG_INIT_SN) + 1) * 8);
    localparam logic [DATA_W-1:0] ALL_ONES    = {DATA_W{1'b1}};

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [7:0]          cipher_byte;
    logic                restart;
    logic                out_valid;
    logic                out_stall;
    logic [7:0]          plain_byte;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // decryptor model state and its copy of the registers
    logic [KEY_W-1:0]    key_a;
    logic [KEY_W-1:0]    key_b;
    logic [SN_W-1:0]     init_sn;
    logic [POS_W-1:0]    pos_a;
    logic [POS_W-1:0]    pos_b;
    logic [SN_W-1:0]     str_num;
    logic                nib_swap;

    logic [7:0]          expected_plain[$];
    int                  errors;
    bit                  in_quiet;
    bit                  out_quiet;

    rolling_key_byte_decryptor_core dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cipher_byte (cipher_byte),
        .restart     (restart),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .plain_byte  (plain_byte),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function logic [7:0] decrypt_byte(input logic [7:0] cb, input logic rs);
        logic [7:0]       t;
        logic [POS_W:0]   na;
        logic [POS_W:0]   nb;
        if (rs)
        begin
            pos_a    = POS_A_INIT;
            pos_b    = POS_B_INIT;
            nib_swap = 1'b0;
            str_num  = init_sn;
        end
        t = key_b[{pos_b, 3'b000} +: 8] ^ {1'b0, str_num} ^ cb;
        if (nib_swap)
            t = {t[3:0], t[7:4]};
        t = t ^ key_a[{pos_a, 3'b000} +: 8];
        na = {1'b0, pos_a} + 5'd1;
        nb = {1'b0, pos_b} + 5'd1;
        if (na <= 5'd15)
        begin
            pos_a = na[POS_W-1:0];
            if (nb > 5'd12)
            begin
                pos_b    = '0;
                nib_swap = ~nib_swap;
            end
            else
                pos_b = nb[POS_W-1:0];
        end
        else if (nb <= 5'd8)
        begin
            pos_a    = '0;
            pos_b    = nb[POS_W-1:0];
            nib_swap = ~nib_swap;
        end
        else
        begin
            // both keys used up
            str_num = str_num + 7'd2;
            if (nib_swap)
            begin
                nib_swap = 1'b0;
                pos_a    = POS_W'(str_num % 7);
                pos_b    = POS_W'(str_num % 12 + 2);
            end
            else
            begin
                nib_swap = 1'b1;
                pos_b    = POS_W'(str_num % 7);
                pos_a    = POS_W'(str_num % 12 + 3);
            end
        end
        return t;
    endfunction

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_reg(input reg_idx_t idx, input logic [DATA_W-1:0] data);
        apb_write({idx, 3'b000}, data);
        case (idx)
            REG_KEY_A_LO: key_a[63:0]   = data;
            REG_KEY_A_HI: key_a[127:64] = data;
            REG_KEY_B_LO: key_b[63:0]   = data;
            REG_KEY_B_HI: key_b[127:64] = data;
            REG_INIT_SN:  init_sn       = data[SN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_keys(input logic [KEY_W-1:0] ka, input logic [KEY_W-1:0] kb,
                             input logic [DATA_W-1:0] sn);
        set_reg(REG_KEY_A_LO, ka[63:0]);
        set_reg(REG_KEY_A_HI, ka[127:64]);
        set_reg(REG_KEY_B_LO, kb[63:0]);
        set_reg(REG_KEY_B_HI, kb[127:64]);
        set_reg(REG_INIT_SN, sn);
    endtask

    function automatic logic [KEY_W-1:0] rand_key();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // entered and left at a falling edge
    task automatic send_beat(input logic [7:0] cb, input logic rs);
        int gap;
        in_valid    <= 1'b1;
        cipher_byte <= cb;
        restart     <= rs;
        do @(posedge clk); while (in_stall);
        expected_plain.push_back(decrypt_byte(cb, rs));
        @(negedge clk);
        gap = in_quiet ? 0 : idle_len();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_plain.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic test_reset_state();
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h5A, 1'b0);
        send_beat(8'hA5, 1'b0);
        drain();
    endtask

    task automatic test_key_wraps();
        load_keys({64'hFFFF_FFFF_FFFF_FFFF, 64'h0F1E_2D3C_4B5A_6978},
                  {64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210}, ALL_ONES);
        send_beat(8'h00, 1'b1);
        send_beat(8'hFF, 1'b0);
        for (int i = 0; i < 16; i++)
            send_beat(8'(i * 17), 1'b0);
        send_beat(8'hFF, 1'b1);
        send_beat(8'h00, 1'b0);
        drain();
    endtask

    task automatic test_unused_register();
        apb_write(UNUSED_ADDR, ALL_ONES);
        send_beat(8'h3C, 1'b1);
        send_beat(8'hC3, 1'b0);
        drain();
    endtask

    task automatic test_random_stream(input int n_items, input int restart_odds,
                                      input bit in_q, input bit out_q);
        in_quiet  = in_q;
        out_quiet = out_q;
        for (int i = 0; i < n_items; i++)
        begin
            send_beat(8'($urandom_range(0, 255)), $urandom_range(0, restart_odds - 1) == 0);
            if (i == n_items / 2)
                drain();
        end
        drain();
    endtask

    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            int n;
            @(negedge clk);
            n = out_quiet ? 0 : idle_len();
            if (n == 0)
                out_stall <= 1'b0;
            else
            begin
                out_stall <= 1'b1;
                repeat (n - 1) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : check_plain
        logic [7:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_plain.size() == 0)
            begin
                $display("%0t: plain_byte expected none got %02h", $time, plain_byte);
                errors++;
            end
            else
            begin
                want = expected_plain.pop_front();
                if (plain_byte !== want)
                begin
                    $display("%0t: plain_byte expected %02h got %02h", $time, want, plain_byte);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #10ms;
        $display("rolling_key_byte_decryptor_core_test NOT OK");
        $finish;
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        cipher_byte = '0;
        restart     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        errors      = 0;
        in_quiet    = 1'b0;
        out_quiet   = 1'b0;
        key_a       = '0;
        key_b       = '0;
        init_sn     = '0;
        pos_a       = POS_A_INIT;
        pos_b       = POS_B_INIT;
        str_num     = '0;
        nib_swap    = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_state();
        test_key_wraps();
        test_unused_register();

        load_keys(rand_key(), rand_key(), {$urandom, $urandom});
        test_random_stream(400, 200, 1'b1, 1'b1);
        load_keys('0, '0, '0);
        test_random_stream(250, 8, 1'b0, 1'b0);
        load_keys({KEY_W{1'b1}}, {KEY_W{1'b1}}, ALL_ONES);
        test_random_stream(300, 150, 1'b0, 1'b0);
        load_keys(rand_key(), rand_key(), {$urandom, $urandom});
        test_random_stream(350, 100, 1'b1, 1'b0);
        load_keys(rand_key(), rand_key(), {$urandom, $urandom});
        test_random_stream(350, 300, 1'b0, 1'b1);

        repeat (10) @(negedge clk);
        if (errors == 0 && expected_plain.size() == 0)
            $display("rolling_key_byte_decryptor_core_test OK");
        else
            $display("rolling_key_byte_decryptor_core_test NOT OK");
        $finish;
    end

endmodule

// ===== rolling_key_byte_decryptor_core.f =====
src/rkbd_pkg.sv
src/rkbd_cfg_regs.sv
src/rkbd_step.sv
src/rolling_key_byte_decryptor_core.sv
src/rkbd_checker.sv
tb/sv/rolling_key_byte_decryptor_core_test.sv
